FILE: rtl/ring_fifo_with_overflow_policy_macros.svh
// Assertion macros shared by the ring FIFO RTL.
`ifndef RING_FIFO_WITH_OVERFLOW_POLICY_MACROS_SVH
`define RING_FIFO_WITH_OVERFLOW_POLICY_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RFIFO_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RFIFO_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rfifo_pkg.sv
// Shared constants and types for the ring FIFO.
package rfifo_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int ITEM_BITS_DEFAULT = 32;
   localparam int DATA_W            = 32;
   localparam int MODE_W            = 2;
   localparam int STATUS_W          = 2;

   // request opcodes; the fourth code is a no-op
   localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // csr register indexes
   localparam logic CSR_POLICY   = 1'b0;
   localparam logic CSR_CAPACITY = 1'b1;

   // overflow policy values
   localparam logic POLICY_DROP_NEW = 1'b0;
   localparam logic POLICY_DROP_OLD = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NEW_DROPPED = 2'd1,
      STATUS_OLD_DROPPED = 2'd2,
      STATUS_POP_EMPTY   = 2'd3
   } status_type;

endpackage

FILE: rtl/rfifo_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rfifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/ring_fifo_with_overflow_policy.sv
// Ring FIFO top level: pointers, count, overflow policy and response stages.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_mode, req_push_data
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_pop_data, rsp_status, rsp_fill_count
//   csr     | in        | csr_we (no wait)     | csr_index, csr_wdata
//
// One request per cycle sustained while rsp_ready stays high. The item store is a
// RAM with a registered read, so popped data is ready in the cycle after the
// request is taken, and a second register holds the finished response.
// Pointers and count update at the accept edge, so back-to-back requests
// never see stale state and a pop right after a push reads the new entry.
// Synchronous active-high reset clears pointers, count and both registers
// (policy drop-newest, capacity DEPTH); the store itself is not cleared.
// A stalled response holds the output register; one more request is still
// taken into the read stage, after which req_ready drops.
module ring_fifo_with_overflow_policy
   import rfifo_pkg::*;
#(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int ITEM_BITS = ITEM_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [MODE_W-1:0]                req_mode,
   input  logic [DATA_W-1:0]                req_push_data,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [DATA_W-1:0]                rsp_pop_data,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]       rsp_fill_count,
   // configuration port
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [$clog2(DEPTH+1)-1:0]       csr_wdata
);

`include "ring_fifo_with_overflow_policy_macros.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CAP_W = $clog2(DEPTH + 1);

   // --- configuration ---
   logic             policy_ff;
   logic [CAP_W-1:0] capacity_ff;

   // --- queue state ---
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CAP_W-1:0] count_ff, count_in;

   // --- read stage (waits on RAM data) ---
   logic             s1_valid_ff;
   logic             s1_pop_ff, s1_pop_in;
   status_type       s1_status_ff, s1_status_in;
   logic [CAP_W-1:0] s1_fill_ff;

   // --- output register ---
   logic              out_valid_ff;
   logic [DATA_W-1:0] out_data_ff;
   status_type        out_status_ff;
   logic [CAP_W-1:0]  out_fill_ff;

   logic               req_accept;
   logic               s1_move;
   logic [CAP_W-1:0]   cap_eff;
   logic               full;
   logic               ram_we;
   logic               ram_re;
   logic [ITEM_BITS-1:0] ram_wdata;
   logic [ITEM_BITS-1:0] ram_rdata;

   // step a pointer, wrapping once it reaches the capacity in use
   function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] p,
                                                    input logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0] nxt;
      nxt = CAP_W'(p) + CAP_W'(1);
      return (nxt >= cap) ? '0 : nxt[PTR_W-1:0];
   endfunction

   // handshakes: read stage drains into the output register when it is free
   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_move;
   assign req_accept = req_valid && req_ready;

   // capacity clamp: zero acts as one, anything above DEPTH acts as DEPTH
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (capacity_ff > CAP_W'(DEPTH)) begin
         cap_eff = CAP_W'(DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end

   assign full = (count_ff >= cap_eff);

   // operation decode and next state
   always_comb begin
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      s1_pop_in    = 1'b0;
      s1_status_in = STATUS_OK;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      if (req_accept) begin
         unique case (req_mode)
            MODE_PUSH: begin
               if (full && (policy_ff == POLICY_DROP_NEW)) begin
                  s1_status_in = STATUS_NEW_DROPPED;
               end else begin
                  ram_we    = 1'b1;
                  wr_ptr_in = ptr_advance(wr_ptr_ff, cap_eff);
                  if (full) begin
                     // evict the oldest entry; count stays put
                     rd_ptr_in    = ptr_advance(rd_ptr_ff, cap_eff);
                     s1_status_in = STATUS_OLD_DROPPED;
                  end else begin
                     count_in = count_ff + CAP_W'(1);
                  end
               end
            end
            MODE_POP: begin
               if (count_ff == '0) begin
                  s1_status_in = STATUS_POP_EMPTY;
               end else begin
                  ram_re    = 1'b1;
                  s1_pop_in = 1'b1;
                  rd_ptr_in = ptr_advance(rd_ptr_ff, cap_eff);
                  count_in  = count_ff - CAP_W'(1);
               end
            end
            MODE_CLEAR: begin
               rd_ptr_in = '0;
               wr_ptr_in = '0;
               count_in  = '0;
            end
            default: begin
               // unused opcode: no operation
            end
         endcase
      end
   end

   assign ram_wdata = ITEM_BITS'(req_push_data);

   rfifo_ram #(
      .WIDTH (ITEM_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rdata)
   );

   // configuration and queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff   <= POLICY_DROP_NEW;
         capacity_ff <= CAP_W'(DEPTH);
         rd_ptr_ff   <= '0;
         wr_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_POLICY:   policy_ff   <= csr_wdata[0];
               CSR_CAPACITY: capacity_ff <= csr_wdata;
               default:      ;
            endcase
         end
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // response pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // response payloads; RAM data is stable while the read stage holds
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pop_ff    <= s1_pop_in;
         s1_status_ff <= s1_status_in;
         s1_fill_ff   <= count_in;
      end
      if (s1_move) begin
         out_data_ff   <= s1_pop_ff ? DATA_W'(ram_rdata) : '0;
         out_status_ff <= s1_status_ff;
         out_fill_ff   <= s1_fill_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_pop_data   = out_data_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_fill_count = out_fill_ff;

   // --- checks ---
   `RFIFO_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CAP_W'(DEPTH), "item count above store depth")

   `RFIFO_ASSERT_NOW(a_empty_pop_fill, clock, reset,
      out_valid_ff && (out_status_ff == STATUS_POP_EMPTY),
      (out_fill_ff == '0) && (out_data_ff == '0), "empty pop reports held items")

   `RFIFO_ASSERT_NEXT(a_pop_decrements, clock, reset,
      req_accept && (req_mode == MODE_POP) && (count_ff != '0),
      count_ff == $past(count_ff) - CAP_W'(1), "pop did not lower the count")

   `RFIFO_ASSERT_NEXT(a_clear_resets, clock, reset,
      req_accept && (req_mode == MODE_CLEAR),
      (rd_ptr_ff == '0) && (wr_ptr_ff == '0) && (count_ff == '0),
      "clear left queue state behind")

endmodule

FILE: test/rfifo_checker.sv
// Ring FIFO checker: watches request, response and csr traffic and predicts responses.
`timescale 1ns / 1ps

module rfifo_checker
   import rfifo_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [DATA_W-1:0]   req_push_data,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [DATA_W-1:0]   rsp_pop_data,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [CNT_W-1:0]    rsp_fill_count,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [CNT_W-1:0]    csr_wdata,
   output int                  fail_count,
   output int                  outstanding
);

   typedef struct {
      logic [DATA_W-1:0] pop_data;
      status_type        status;
      logic [CNT_W-1:0]  fill;
   } fifo_result_type;

   fifo_result_type   awaited_rsp_q[$];

   // shadow of the queue and its registers
   logic [DATA_W-1:0] slot_mem [DEPTH];
   int                rd_ptr;
   int                wr_ptr;
   int                held;
   logic              policy;
   logic [CNT_W-1:0]  cap_reg;
   int                errs = 0;

   assign fail_count = errs;

   function automatic int active_capacity();
      int c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   // pointer step, wraps by compare against the capacity in use
   function automatic int step_ptr(int p, int cap);
      return (p + 1 >= cap) ? 0 : p + 1;
   endfunction

   function automatic fifo_result_type apply_request(logic [MODE_W-1:0] mode,
                                                     logic [DATA_W-1:0] data);
      fifo_result_type r;
      int              cap;
      logic            full;
      cap        = active_capacity();
      r.pop_data = '0;
      r.status   = STATUS_OK;
      case (mode)
         MODE_PUSH: begin
            full = (held >= cap);
            if (full && policy == POLICY_DROP_NEW) begin
               r.status = STATUS_NEW_DROPPED;
            end else begin
               if (full) begin
                  rd_ptr   = step_ptr(rd_ptr, cap);
                  held     = held - 1;
                  r.status = STATUS_OLD_DROPPED;
               end
               slot_mem[wr_ptr % DEPTH] = data;
               wr_ptr = step_ptr(wr_ptr, cap);
               held   = held + 1;
            end
         end
         MODE_POP: begin
            if (held == 0) begin
               r.status = STATUS_POP_EMPTY;
            end else begin
               r.pop_data = slot_mem[rd_ptr % DEPTH];
               rd_ptr     = step_ptr(rd_ptr, cap);
               held       = held - 1;
            end
         end
         MODE_CLEAR: begin
            rd_ptr = 0;
            wr_ptr = 0;
            held   = 0;
         end
         default: ;
      endcase
      r.fill = CNT_W'(held);
      return r;
   endfunction

   task automatic flag_mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errs++;
      $error("%s mismatch: expected %0h, actual %0h", field, want, got);
   endtask

   always @(posedge clock) begin
      fifo_result_type want;
      if (reset) begin
         rd_ptr  = 0;
         wr_ptr  = 0;
         held    = 0;
         policy  = POLICY_DROP_NEW;
         cap_reg = CNT_W'(DEPTH);
         awaited_rsp_q.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_POLICY)
               policy = csr_wdata[0];
            else
               cap_reg = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp_q.size() == 0) begin
               errs++;
               $error("response with no request pending: pop_data %0h status %0d",
                      rsp_pop_data, rsp_status);
            end else begin
               want = awaited_rsp_q.pop_front();
               if (rsp_pop_data !== want.pop_data)
                  flag_mismatch("pop_data", want.pop_data, rsp_pop_data);
               if (rsp_status !== want.status)
                  flag_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
               if (rsp_fill_count !== want.fill)
                  flag_mismatch("fill_count", DATA_W'(want.fill), DATA_W'(rsp_fill_count));
            end
         end
         if (req_valid && req_ready)
            awaited_rsp_q.push_back(apply_request(req_mode, req_push_data));
      end
      outstanding <= awaited_rsp_q.size();
   end

endmodule

FILE: test/tb_top.sv
// Ring FIFO testbench top: clock, reset, request stimulus, response stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
   import rfifo_pkg::*;

   localparam int DEPTH       = DEPTH_DEFAULT;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int HOLD_CYCLES = 400;   // long receiver hold-off
   localparam int STUCK_LIMIT = 5000;  // cycles with no handshake before giving up
   localparam int PHASES      = 14;
   localparam int PHASE_REQS  = 120;

   logic                clock;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic [MODE_W-1:0]   req_mode      = MODE_PUSH;
   logic [DATA_W-1:0]   req_push_data = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [DATA_W-1:0]   rsp_pop_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [CNT_W-1:0]    rsp_fill_count;
   logic                csr_we        = 1'b0;
   logic                csr_index     = CSR_POLICY;
   logic [CNT_W-1:0]    csr_wdata     = '0;

   int                  fail_count;
   int                  outstanding;

   // steady: neither side idles; hold_seq bumps to ask for a receiver hold-off
   logic                steady        = 1'b0;
   int                  hold_seq      = 0;
   int                  hold_seen     = 0;
   int                  hold_left     = 0;
   int                  stuck_cycles  = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   ring_fifo_with_overflow_policy #(
      .DEPTH     (DEPTH),
      .ITEM_BITS (ITEM_BITS_DEFAULT)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_data  (req_push_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   rfifo_checker #(
      .DEPTH (DEPTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_push_data  (req_push_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pop_data   (rsp_pop_data),
      .rsp_status     (rsp_status),
      .rsp_fill_count (rsp_fill_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .fail_count     (fail_count),
      .outstanding    (outstanding)
   );

   // Receiver: random back-pressure, or a counted hold-off when one is asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seq != hold_seen) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 26);
      end
   end

   // Watchdog: a hang shows up as a long run of cycles with no handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offer one request and hold it until taken. Random idle cycles go in front
   // unless the steady stretch is on. Valid stays up between back-to-back requests.
   task automatic send_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_push_data <= data;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and wait for every predicted response to come back.
   // The first edge lets the checker count the last accepted request.
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Single-cycle csr write pulse; only called with the block drained.
   task automatic write_csr(input logic index, input logic [CNT_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // Policy write with junk in the unused upper bits.
   task automatic write_policy(input logic pol);
      logic [CNT_W-1:0] v;
      v    = CNT_W'($urandom);
      v[0] = pol;
      write_csr(CSR_POLICY, v);
   endtask

   function automatic logic [DATA_W-1:0] pick_data();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return DATA_W'($urandom);
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_capacity();
      case ($urandom_range(9))
         0:       return '0;                          // acts as 1
         1:       return '1;                          // above DEPTH, acts as DEPTH
         2:       return CNT_W'(DEPTH);
         3:       return CNT_W'(1);
         4, 5, 6: return CNT_W'($urandom_range(8, 2)); // small, so full is hit often
         default: return CNT_W'($urandom_range(DEPTH, 1));
      endcase
   endfunction

   initial begin
      int push_pct;
      int taken;
      int roll;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Write every store slot once at full capacity, so no later pop can
      // land on a slot that was never written, whatever the capacity does.
      // Also hits full with drop-newest and a pop from a full queue.
      send_request(MODE_PUSH, '0);
      for (int i = 1; i < DEPTH - 1; i++)
         send_request(MODE_PUSH, DATA_W'($urandom));
      send_request(MODE_PUSH, '1);
      send_request(MODE_PUSH, 32'hDEAD_BEEF);
      send_request(MODE_POP, '0);
      send_request(MODE_CLEAR, DATA_W'($urandom));

      // Empty pop, unused mode, data extremes and patterns, clear with items held.
      send_request(MODE_POP, '1);
      send_request(MODE_UNUSED, DATA_W'($urandom));
      send_request(MODE_PUSH, '0);
      send_request(MODE_PUSH, '1);
      send_request(MODE_PUSH, 32'hA5A5_A5A5);
      send_request(MODE_PUSH, 32'h5A5A_5A5A);
      send_request(MODE_POP, '0);
      send_request(MODE_POP, '0);
      send_request(MODE_CLEAR, '0);
      send_request(MODE_POP, '0);
      drain_responses();

      // Capacity one with drop-oldest: second push evicts the first.
      write_policy(POLICY_DROP_OLD);
      write_csr(CSR_CAPACITY, CNT_W'(1));
      send_request(MODE_PUSH, 32'h1111_1111);
      send_request(MODE_PUSH, 32'h2222_2222);
      send_request(MODE_POP, '0);
      send_request(MODE_POP, '0);
      drain_responses();

      // Capacity zero behaves as one; then drop-newest on the full queue.
      write_csr(CSR_CAPACITY, '0);
      send_request(MODE_PUSH, 32'h3333_3333);
      send_request(MODE_PUSH, 32'h4444_4444);
      drain_responses();
      write_policy(POLICY_DROP_NEW);
      send_request(MODE_PUSH, 32'h5555_5555);
      send_request(MODE_POP, '0);
      drain_responses();

      // Capacity above DEPTH clamps; then shrink below the count while items are held.
      write_csr(CSR_CAPACITY, '1);
      send_request(MODE_PUSH, 32'h6666_6666);
      send_request(MODE_PUSH, 32'h7777_7777);
      send_request(MODE_PUSH, 32'h8888_8888);
      drain_responses();
      write_csr(CSR_CAPACITY, CNT_W'(2));
      send_request(MODE_PUSH, 32'h9999_9999);
      drain_responses();
      write_policy(POLICY_DROP_OLD);
      send_request(MODE_PUSH, 32'hAAAA_AAAA);
      send_request(MODE_POP, '0);
      send_request(MODE_POP, '0);
      send_request(MODE_POP, '0);
      send_request(MODE_POP, '0);
      drain_responses();

      // Random phases, each under its own settings. State is often carried
      // across a phase boundary, so capacity changes land on a held queue.
      for (int ph = 0; ph < PHASES; ph++) begin
         write_policy(logic'($urandom_range(1)));
         write_csr(CSR_CAPACITY, pick_capacity());
         if ($urandom_range(2) == 0)
            send_request(MODE_CLEAR, pick_data());

         case ($urandom_range(2))
            0:       push_pct = 30;
            1:       push_pct = 50;
            default: push_pct = 70;
         endcase

         // one phase runs with no idling at all on either side
         if (ph == 5)
            steady <= 1'b1;
         // push-heavy phase starts with a long receiver hold-off, so the
         // block backs up and drops req_ready while requests keep coming
         if (ph == 2) begin
            push_pct = 70;
            hold_seq <= hold_seq + 1;
         end

         taken = 0;
         while (taken < PHASE_REQS) begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               send_request(MODE_PUSH, pick_data());
               taken++;
            end else if (roll < 96) begin
               send_request(MODE_POP, DATA_W'($urandom));
               taken++;
            end else if (roll < 99) begin
               send_request(MODE_CLEAR, DATA_W'($urandom));
               taken++;
            end else begin
               // unused mode: ignored by the block, not counted
               send_request(MODE_UNUSED, DATA_W'($urandom));
            end
         end

         if (ph == 5)
            steady <= 1'b0;
         // sender pauses here until every response is back
         drain_responses();
      end

      // spare cycles to catch any stray response after the last one
      repeat (8) @(posedge clock);

      if (fail_count == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: ring_fifo_with_overflow_policy.f
+incdir+rtl
rtl/rfifo_pkg.sv
rtl/rfifo_ram.sv
rtl/ring_fifo_with_overflow_policy.sv
test/rfifo_checker.sv
test/tb_top.sv
